### hw/rtl/buddy_block_allocator_unit_defines.svh
// buddy_block_allocator_unit_defines.svh
// assertion macros shared by the buddy allocator rtl; no dependencies
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication under synchronous reset
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator assertion failed");

// next-cycle implication under synchronous reset
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator assertion failed");

`endif

### hw/rtl/bba_pkg.sv
// bba_pkg.sv
// types and constants of the buddy block allocator; no dependencies
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MIN_ORDER    = 8;
    localparam int MAX_ORDER    = 17;
    localparam int LEVELS       = MAX_ORDER - MIN_ORDER + 1;
    localparam int TOP_CHUNKS   = 8;
    localparam int BORDER_BYTES = 32;
    localparam int HALF_BORDER  = BORDER_BYTES / 2;
    localparam int CHUNK_SHIFT  = MAX_ORDER - MIN_ORDER;
    localparam int UNITS        = TOP_CHUNKS << CHUNK_SHIFT;
    localparam int UNIT_W       = $clog2(UNITS);
    localparam int LINK_W       = UNIT_W + 1;
    localparam int LVL_W        = 4;
    localparam int ADDR_W       = 20;
    localparam int CNT_W        = 4;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(UNITS);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [16:0] request_bytes;
        logic [19:0] user_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] result_offset;
        logic [4:0]  block_order;
    } t_rsp;

    typedef struct packed {
        logic [UNIT_W-1:0] rd_addr;
        logic              next_we;
        logic [UNIT_W-1:0] next_addr;
        logic [LINK_W-1:0] next_data;
        logic              prev_we;
        logic [UNIT_W-1:0] prev_addr;
        logic [LINK_W-1:0] prev_data;
        logic              mark_we;
        logic [UNIT_W-1:0] mark_addr;
        logic [LVL_W-1:0]  mark_data;
    } t_mem_req;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [LVL_W-1:0]  mark;
    } t_mem_rsp;

endpackage

### hw/rtl/bba_links.sv
// bba_links.sv
// per-unit link and free-mark memories, one read address, registered data
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_links
    import bba_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [LINK_W-1:0] r_next_mem [UNITS];
    logic [LINK_W-1:0] r_prev_mem [UNITS];
    logic [LVL_W-1:0]  r_mark_mem [UNITS];
    t_mem_rsp          r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.next_we) begin
            r_next_mem[i_req.next_addr] <= i_req.next_data;
        end
        r_rsp.next <= r_next_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.prev_we) begin
            r_prev_mem[i_req.prev_addr] <= i_req.prev_data;
        end
        r_rsp.prev <= r_prev_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mark_we) begin
            r_mark_mem[i_req.mark_addr] <= i_req.mark_data;
        end
        r_rsp.mark <= r_mark_mem[i_req.rd_addr];
    end

    assign o_rsp = r_rsp;

endmodule

### hw/rtl/buddy_block_allocator_unit.sv
// buddy_block_allocator_unit.sv
// buddy allocator top level: sequencer, list heads, output register
// depends on bba_pkg, bba_links and buddy_block_allocator_unit_defines.svh
//
// usage: request words (alloc or free) enter on i_in_valid / o_in_ready,
// one answer word per request leaves on o_out_valid / i_out_ready.
// the fresh chunk limit is written through i_cfg_we / i_cfg_wdata while idle.
// one request at a time: a sequencer walks the free lists, one memory
// access per cycle on the shared link memory port.
// a size out of range or a free outside taken chunks is answered at idle;
// alloc probes one list head per order (up to 10, out of memory answers
// there), unlinks a listed block, pushes the upper half at each split and
// answers; free reads its unit's mark (a double free is answered there),
// merges while the buddy of the same order is free, pushes and answers.
// after reset the free marks are swept to zero, one unit a cycle, over all
// 4096 units; input ready stays low during the sweep.
// the answer sits in an output register; a stalled receiver holds it and
// the next request is taken only once that register is free or drained.
`timescale 1ns / 1ps
`include "buddy_block_allocator_unit_defines.svh"

module buddy_block_allocator_unit
    import bba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_data,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_ARD   = 4'd3;
    localparam logic [3:0] S_AUL   = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PCHK  = 4'd7;
    localparam logic [3:0] S_PW1   = 4'd8;
    localparam logic [3:0] S_PW2   = 4'd9;
    localparam logic [3:0] S_FRD   = 4'd10;
    localparam logic [3:0] S_FCHK  = 4'd11;
    localparam logic [3:0] S_MRD   = 4'd12;
    localparam logic [3:0] S_MCHK  = 4'd13;
    localparam logic [3:0] S_FFIN  = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_ret, n_ret;
    logic [4:0]        r_ord, n_ord;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [LVL_W-1:0]  r_k, n_k;
    logic [UNIT_W-1:0] r_u, n_u;
    logic [UNIT_W-1:0] r_b, n_b;
    logic [UNIT_W-1:0] r_pu, n_pu;
    logic [LVL_W-1:0]  r_plvl, n_plvl;
    logic [LINK_W-1:0] r_pn, n_pn;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_limit;
    logic [UNIT_W-1:0] r_clr;
    logic [LINK_W-1:0] r_heads [LEVELS];
    logic [LINK_W-1:0] n_heads [LEVELS];
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    t_mem_req          mem_req;
    t_mem_rsp          mem_rsp;

    logic              accept;
    logic [17:0]       total;
    logic [4:0]        req_ord;
    logic [ADDR_W-1:0] free_start;
    logic [UNIT_W-1:0] merge_b;
    logic [UNIT_W-1:0] ul_unit;
    logic              ul_en;
    logic [LVL_W-1:0]  ul_lvl;

    bba_links u_links (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign total      = {1'b0, i_in_data.request_bytes} + 18'(BORDER_BYTES);
    assign merge_b    = r_u ^ (UNIT_W'(1) << r_lvl);
    assign ul_lvl     = mem_rsp.mark - LVL_W'(1);

    // smallest order that holds the request plus border
    always_comb begin
        req_ord = 5'(MAX_ORDER);
        for (int i = MAX_ORDER - 1; i >= MIN_ORDER; i--) begin
            if ((18'(1) << i) >= total) begin
                req_ord = 5'(i);
            end
        end
    end

    always_comb begin
        free_start = i_in_data.user_offset - ADDR_W'(HALF_BORDER);
        free_start = free_start & ~((ADDR_W'(1) << req_ord) - ADDR_W'(1));
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_ord       = r_ord;
        n_lvl       = r_lvl;
        n_k         = r_k;
        n_u         = r_u;
        n_b         = r_b;
        n_pu        = r_pu;
        n_plvl      = r_plvl;
        n_pn        = r_pn;
        n_used      = r_used;
        n_heads     = r_heads;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ul_en       = 1'b0;
        ul_unit     = r_u;

        mem_req           = '0;
        mem_req.rd_addr   = r_u;
        mem_req.next_addr = r_u;
        mem_req.prev_addr = r_u;
        mem_req.mark_addr = r_u;

        unique case (r_state)
            S_CLEAR: begin
                mem_req.mark_we   = 1'b1;
                mem_req.mark_addr = r_clr;
                mem_req.mark_data = '0;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_ord = req_ord;
                    n_lvl = LVL_W'(req_ord - 5'(MIN_ORDER));
                    n_k   = LVL_W'(req_ord - 5'(MIN_ORDER));
                    if (total > 18'((1 << MAX_ORDER) - 1)) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_RANGE, result_offset: '0, block_order: '0};
                    end else if (i_in_data.operation == OP_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (CNT_W'(free_start[ADDR_W-1:MAX_ORDER]) >= r_used) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_OK, result_offset: '0, block_order: req_ord};
                    end else begin
                        n_u     = free_start[ADDR_W-1:MIN_ORDER];
                        n_state = S_FRD;
                    end
                end
            end
            S_SCAN: begin
                if (!r_heads[r_k][UNIT_W]) begin
                    n_u     = r_heads[r_k][UNIT_W-1:0];
                    n_state = S_ARD;
                end else if (r_k == LVL_W'(LEVELS - 1)) begin
                    if (r_used < r_limit && r_used < CNT_W'(TOP_CHUNKS)) begin
                        n_u     = UNIT_W'(r_used) << CHUNK_SHIFT;
                        n_used  = r_used + CNT_W'(1);
                        n_state = S_SPLIT;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_OOM, result_offset: '0, block_order: r_ord};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_k = r_k + LVL_W'(1);
                end
            end
            S_ARD: begin
                n_state = S_AUL;
            end
            S_AUL: begin
                ul_en   = 1'b1;
                ul_unit = r_u;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (r_k > r_lvl) begin
                    n_k     = r_k - LVL_W'(1);
                    n_pu    = r_u + (UNIT_W'(1) << (r_k - LVL_W'(1)));
                    n_plvl  = r_k - LVL_W'(1);
                    n_ret   = S_SPLIT;
                    n_state = S_PRD;
                end else begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK,
                                    result_offset: (ADDR_W'(r_u) << MIN_ORDER)
                                                   + ADDR_W'(HALF_BORDER),
                                    block_order: r_ord};
                    n_state     = S_IDLE;
                end
            end
            S_PRD: begin
                mem_req.rd_addr = r_pu;
                n_state         = S_PCHK;
            end
            S_PCHK: begin
                // overlapping push: take the unit off its old list first
                if (mem_rsp.mark != '0) begin
                    ul_en   = 1'b1;
                    ul_unit = r_pu;
                end
                n_state = S_PW1;
            end
            S_PW1: begin
                mem_req.next_we   = 1'b1;
                mem_req.next_addr = r_pu;
                mem_req.next_data = r_heads[r_plvl];
                mem_req.prev_we   = 1'b1;
                mem_req.prev_addr = r_pu;
                mem_req.prev_data = NIL;
                mem_req.mark_we   = 1'b1;
                mem_req.mark_addr = r_pu;
                mem_req.mark_data = r_plvl + LVL_W'(1);
                n_pn              = r_heads[r_plvl];
                n_heads[r_plvl]   = LINK_W'(r_pu);
                n_state           = S_PW2;
            end
            S_PW2: begin
                if (!r_pn[UNIT_W]) begin
                    mem_req.prev_we   = 1'b1;
                    mem_req.prev_addr = r_pn[UNIT_W-1:0];
                    mem_req.prev_data = LINK_W'(r_pu);
                end
                n_state = r_ret;
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                // double free leaves the lists alone
                if (mem_rsp.mark != '0) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, result_offset: '0, block_order: r_ord};
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                if (r_lvl == LVL_W'(LEVELS - 1)) begin
                    n_pu    = r_u;
                    n_plvl  = r_lvl;
                    n_ret   = S_FFIN;
                    n_state = S_PRD;
                end else begin
                    mem_req.rd_addr = merge_b;
                    n_b             = merge_b;
                    n_state         = S_MCHK;
                end
            end
            S_MCHK: begin
                if (mem_rsp.mark != r_lvl + LVL_W'(1)) begin
                    n_pu    = r_u;
                    n_plvl  = r_lvl;
                    n_ret   = S_FFIN;
                    n_state = S_PRD;
                end else begin
                    ul_en   = 1'b1;
                    ul_unit = r_b;
                    n_u     = (r_b < r_u) ? r_b : r_u;
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = S_MRD;
                end
            end
            S_FFIN: begin
                n_out_valid = 1'b1;
                n_out       = '{status: ST_OK, result_offset: '0, block_order: r_ord};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // unlink of ul_unit using the word just read for it
        if (ul_en && mem_rsp.mark != '0) begin
            mem_req.mark_we   = 1'b1;
            mem_req.mark_addr = ul_unit;
            mem_req.mark_data = '0;
            if (ul_lvl < LVL_W'(LEVELS)) begin
                if (!mem_rsp.prev[UNIT_W]) begin
                    mem_req.next_we   = 1'b1;
                    mem_req.next_addr = mem_rsp.prev[UNIT_W-1:0];
                    mem_req.next_data = mem_rsp.next;
                end else begin
                    n_heads[ul_lvl] = mem_rsp.next;
                end
                if (!mem_rsp.next[UNIT_W]) begin
                    mem_req.prev_we   = 1'b1;
                    mem_req.prev_addr = mem_rsp.next[UNIT_W-1:0];
                    mem_req.prev_data = mem_rsp.prev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_limit     <= CNT_W'(8);
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_heads[i] <= NIL;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= r_clr + UNIT_W'(1);
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_heads     <= n_heads;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_ord  <= n_ord;
        r_lvl  <= n_lvl;
        r_k    <= n_k;
        r_u    <= n_u;
        r_b    <= n_b;
        r_pu   <= n_pu;
        r_plvl <= n_plvl;
        r_pn   <= n_pn;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BBA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `BBA_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, accept, r_state != S_IDLE || o_out_valid)
    `BBA_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(TOP_CHUNKS))
    `BBA_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !o_out_valid && !o_in_ready)

endmodule

### verif/buddy_block_allocator_unit_checker.sv
// buddy_block_allocator_unit_checker.sv
// watches the request, answer and config ports, predicts each answer word and compares
// depends on bba_pkg
`timescale 1ns / 1ps

module buddy_block_allocator_unit_checker
    import bba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_req       i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_rsp       i_out_data,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending
);

    logic [LINK_W-1:0] heads [LEVELS];
    logic [LINK_W-1:0] nxt [UNITS];
    logic [LINK_W-1:0] prv [UNITS];
    logic [LVL_W-1:0]  marks [UNITS];
    logic [CNT_W-1:0]  chunks_taken;
    logic [3:0]        chunk_limit;
    t_rsp              answers_due [$];

    assign o_pending = answers_due.size();

    function automatic void take_off_list(int u);
        int lvl;
        logic [LINK_W-1:0] p, n;
        if (u >= UNITS || marks[u] == 0) return;
        lvl = int'(marks[u]) - 1;
        if (lvl >= LEVELS) begin
            marks[u] = 0;
            return;
        end
        p = prv[u];
        n = nxt[u];
        if (p < UNITS) nxt[p] = n; else heads[lvl] = n;
        if (n < UNITS) prv[n] = p;
        marks[u] = 0;
    endfunction

    function automatic void put_on_list(int u, int lvl);
        logic [LINK_W-1:0] n;
        if (u >= UNITS || lvl >= LEVELS) return;
        if (marks[u] != 0) take_off_list(u);
        n = heads[lvl];
        nxt[u] = n;
        prv[u] = NIL;
        if (n < UNITS) prv[n] = LINK_W'(u);
        heads[lvl] = LINK_W'(u);
        marks[u] = LVL_W'(lvl + 1);
    endfunction

    function automatic t_rsp serve_request(t_req w);
        t_rsp r;
        int total, ord, lvl, k, u, b;
        logic [19:0] start;
        r = '0;
        total = int'(w.request_bytes) + BORDER_BYTES;
        if (total > (1 << MAX_ORDER) - 1) begin
            r.status = ST_RANGE;
            return r;
        end
        ord = MIN_ORDER;
        while (ord < MAX_ORDER && (1 << ord) < total) ord++;
        lvl = ord - MIN_ORDER;
        r.block_order = 5'(ord);
        if (w.operation == OP_ALLOC) begin
            k = lvl;
            while (k < LEVELS && heads[k] >= UNITS) k++;
            if (k >= LEVELS) begin
                if (chunks_taken < chunk_limit && chunks_taken < TOP_CHUNKS) begin
                    u = int'(chunks_taken) << CHUNK_SHIFT;
                    chunks_taken++;
                    k = LEVELS - 1;
                end else begin
                    r.status = ST_OOM;
                    return r;
                end
            end else begin
                u = int'(heads[k]);
                take_off_list(u);
            end
            while (k > lvl) begin
                k--;
                put_on_list(u + (1 << k), k);
            end
            r.result_offset = 20'((u << MIN_ORDER) + HALF_BORDER);
            return r;
        end
        start = w.user_offset - 20'(HALF_BORDER);
        start &= ~20'((1 << ord) - 1);
        if (int'(start >> MAX_ORDER) >= int'(chunks_taken)) return r;
        u = int'(start >> MIN_ORDER);
        if (u >= UNITS || marks[u] != 0) return r;
        // merge upward while the buddy is free at the same order
        while (lvl < LEVELS - 1) begin
            b = u ^ (1 << lvl);
            if (b >= UNITS || marks[b] != LVL_W'(lvl + 1)) break;
            take_off_list(b);
            if (b < u) u = b;
            lvl++;
        end
        put_on_list(u, lvl);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) heads[i] = NIL;
            for (int i = 0; i < UNITS; i++) begin
                nxt[i] = '0;
                prv[i] = '0;
                marks[i] = '0;
            end
            chunks_taken = '0;
            chunk_limit = 4'd8;
            answers_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer word %p", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status != i_out_data.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, i_out_data.status);
                        o_fail_count++;
                    end
                    if (want.result_offset != i_out_data.result_offset) begin
                        $display("%0t: result_offset expected %h actual %h", $time,
                                 want.result_offset, i_out_data.result_offset);
                        o_fail_count++;
                    end
                    if (want.block_order != i_out_data.block_order) begin
                        $display("%0t: block_order expected %0d actual %0d", $time,
                                 want.block_order, i_out_data.block_order);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) chunk_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready) answers_due.push_back(serve_request(i_in_data));
        end
    end

endmodule

### verif/buddy_block_allocator_unit_tb.sv
// buddy_block_allocator_unit_tb.sv
// stimulus and verdict for the buddy allocator: directed corners, then random alloc/free
// depends on bba_pkg, buddy_block_allocator_unit and buddy_block_allocator_unit_checker
`timescale 1ns / 1ps

module buddy_block_allocator_unit_tb;
    import bba_pkg::*;

    typedef struct {
        logic [19:0] offset;
        logic [16:0] req;
    } t_live;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_req       i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_rsp       o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;
    int         fail_count;
    int         pending;
    bit         calm = 1'b0;
    t_req       sent_words [$];
    t_live      live_blocks [$];
    t_live      freed_blocks [$];
    int         n_words = 0, n_alloc_ok = 0, n_oom = 0, n_range = 0, n_free = 0;

    always #5 i_clk = ~i_clk;

    buddy_block_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    buddy_block_allocator_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // track live blocks so the random part can free real allocations
    always @(posedge i_clk) begin
        t_req w;
        t_live b;
        if (o_out_valid && i_out_ready && sent_words.size() != 0) begin
            w = sent_words.pop_front();
            if (o_out_data.status == ST_RANGE) n_range++;
            else if (o_out_data.status == ST_OOM) n_oom++;
            else if (w.operation == OP_FREE) n_free++;
            else begin
                n_alloc_ok++;
                b.offset = o_out_data.result_offset;
                b.req = w.request_bytes;
                live_blocks.push_back(b);
            end
        end
    end

    task automatic send_word(input logic op, input logic [16:0] req, input logic [19:0] uoff);
        t_req w;
        w.operation = op;
        w.request_bytes = req;
        w.user_offset = uoff;
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sent_words.push_back(w);
        n_words++;
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [3:0] v);
        drain_all();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [16:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 17'($urandom_range(480));
        if (r < 85) return 17'($urandom_range(4000));
        if (r < 96) return 17'($urandom_range(40000));
        if (r < 98) return 17'($urandom_range(131039));
        return 17'($urandom);
    endfunction

    task automatic random_word();
        int r, idx;
        t_live b;
        r = $urandom_range(99);
        if (r < 52 || live_blocks.size() == 0) begin
            send_word(OP_ALLOC, pick_size(), 20'($urandom));
        end else if (r < 88) begin
            idx = $urandom_range(live_blocks.size() - 1);
            b = live_blocks[idx];
            live_blocks.delete(idx);
            freed_blocks.push_back(b);
            if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
            // sometimes a pointer inside the block rather than at its start
            if ($urandom_range(9) == 0) b.offset += 20'($urandom_range(200));
            send_word(OP_FREE, b.req, b.offset);
        end else if (r < 94 && freed_blocks.size() != 0) begin
            b = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
            send_word(OP_FREE, b.req, b.offset);
        end else begin
            send_word(OP_FREE, 17'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners with a single fresh chunk
        set_limit(4'd1);
        send_word(OP_ALLOC, 17'd131039, 20'hFFFFF);
        send_word(OP_ALLOC, 17'd0, 20'd0);
        send_word(OP_ALLOC, 17'd131040, 20'd0);
        send_word(OP_ALLOC, 17'h1FFFF, 20'hFFFFF);
        send_word(OP_FREE, 17'h1FFFF, 20'd16);
        drain_all();
        send_word(OP_FREE, 17'd131039, 20'd16);
        send_word(OP_FREE, 17'd131039, 20'd16);
        send_word(OP_ALLOC, 17'd224, 20'd0);
        send_word(OP_ALLOC, 17'd225, 20'd0);
        send_word(OP_ALLOC, 17'd0, 20'd0);
        send_word(OP_FREE, 17'd0, 20'hFFFFF);
        send_word(OP_FREE, 17'd0, 20'h20010);
        send_word(OP_FREE, 17'd0, 20'd0);
        send_word(OP_FREE, 17'd225, 20'd300);
        send_word(OP_FREE, 17'd224, 20'd16);
        send_word(OP_FREE, 17'd224, 20'd16);
        send_word(OP_ALLOC, 17'd65504, 20'd0);
        send_word(OP_ALLOC, 17'd65505, 20'd0);
        drain_all();
        live_blocks.delete();

        set_limit(4'd15);
        calm = 1'b1;
        for (int i = 0; i < 500; i++) begin
            if (i == 150) calm = 1'b0;
            random_word();
        end
        set_limit(4'd0);
        for (int i = 0; i < 500; i++) random_word();
        set_limit(4'd3);
        for (int i = 0; i < 500; i++) random_word();
        set_limit(4'd8);
        for (int i = 0; i < 500; i++) random_word();
        drain_all();

        $display("ran %0d request words: %0d good allocs, %0d frees answered ok,",
                 n_words, n_alloc_ok, n_free);
        $display("%0d out-of-memory and %0d out-of-range answers", n_oom, n_range);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_links.sv
hw/rtl/buddy_block_allocator_unit.sv
verif/buddy_block_allocator_unit_checker.sv
verif/buddy_block_allocator_unit_tb.sv
